// ----- src/rhc_pkg.sv -----
// Shared types and constants for the RGB to HSV conversion pipeline.
// No dependencies; every other file in src refers to this package.
package rhc_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int HUE_W          = 11;
    localparam int HUE_SIXTH_LOG  = 8;
    // Hue quotient is at most one sixth of a turn, so it needs one bit more.
    localparam int HQ_W           = HUE_SIXTH_LOG + 1;
    localparam int DIV_STEPS      = (COMPONENT_BITS > HQ_W) ? COMPONENT_BITS : HQ_W;
    localparam int HN_W           = COMPONENT_BITS + HUE_SIXTH_LOG;
    localparam int SN_W           = 2 * COMPONENT_BITS;
    localparam int SNP_W          = (SN_W > DIV_STEPS) ? SN_W : DIV_STEPS;
    // Input register, min/max, setup, divider steps and output register.
    localparam int NUM_STAGES     = DIV_STEPS + 4;

    localparam logic [HUE_W-1:0] HUE_BASE_BLUE_MIN  = HUE_W'(1 << HUE_SIXTH_LOG);
    localparam logic [HUE_W-1:0] HUE_BASE_RED_MIN   = HUE_W'(3 << HUE_SIXTH_LOG);
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN_MIN = HUE_W'(5 << HUE_SIXTH_LOG);

    typedef logic [COMPONENT_BITS-1:0] t_comp;

    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
    } t_rgb_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        t_comp            saturation;
        t_comp            brightness;
        logic             hue_undefined;
    } t_hsv_pixel;

    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
        t_comp mn;
        t_comp mx;
    } t_minmax;

    // Both dividers run side by side; each accumulator holds the dividend
    // bits not yet consumed in its upper part and the quotient in its lower.
    typedef struct packed {
        t_comp                hue_rem;
        logic [DIV_STEPS-1:0] hue_acc;
        t_comp                sat_rem;
        logic [DIV_STEPS-1:0] sat_acc;
        t_comp                diff;
        t_comp                mx;
        logic [HUE_W-1:0]     base;
        logic                 neg;
        logic                 undef;
    } t_div;

endpackage

// ----- src/rhc_minmax.sv -----
// Finds the smallest and largest color component of one pixel.
// Uses rhc_pkg for the pixel types.
module rhc_minmax (
    input  rhc_pkg::t_rgb_pixel i_pixel,
    output rhc_pkg::t_minmax    o_mm
);

    rhc_pkg::t_comp mn_rg;
    rhc_pkg::t_comp mx_rg;

    always_comb begin
        mn_rg = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        mx_rg = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
        o_mm.red   = i_pixel.red;
        o_mm.green = i_pixel.green;
        o_mm.blue  = i_pixel.blue;
        o_mm.mn    = (i_pixel.blue < mn_rg) ? i_pixel.blue : mn_rg;
        o_mm.mx    = (i_pixel.blue > mx_rg) ? i_pixel.blue : mx_rg;
    end

endmodule

// ----- src/rhc_setup.sv -----
// Picks the hue sector and signed difference, and loads both dividers.
// Uses rhc_pkg for types and sector constants.
module rhc_setup (
    input  rhc_pkg::t_minmax i_mm,
    output rhc_pkg::t_div    o_div
);

    rhc_pkg::t_comp                    diff;
    rhc_pkg::t_comp                    op_a;
    rhc_pkg::t_comp                    op_b;
    rhc_pkg::t_comp                    abs_f;
    logic [rhc_pkg::HN_W-1:0]          hnum;
    logic [rhc_pkg::SN_W-1:0]          snum;
    logic [rhc_pkg::SNP_W-1:0]         snum_p;

    always_comb begin
        diff = i_mm.mx - i_mm.mn;
        // Red wins ties for the minimum, then green: red maximum with green
        // and blue tied therefore lands at the top of the scale.
        if (i_mm.red == i_mm.mn) begin
            o_div.base = rhc_pkg::HUE_BASE_RED_MIN;
            op_a = i_mm.green;
            op_b = i_mm.blue;
        end else if (i_mm.green == i_mm.mn) begin
            o_div.base = rhc_pkg::HUE_BASE_GREEN_MIN;
            op_a = i_mm.blue;
            op_b = i_mm.red;
        end else begin
            o_div.base = rhc_pkg::HUE_BASE_BLUE_MIN;
            op_a = i_mm.red;
            op_b = i_mm.green;
        end
        o_div.neg = (op_a < op_b);
        abs_f = o_div.neg ? (op_b - op_a) : (op_a - op_b);

        hnum = {abs_f, {rhc_pkg::HUE_SIXTH_LOG{1'b0}}};
        // d * full scale, written as d shifted up minus d.
        snum = {diff, {rhc_pkg::COMPONENT_BITS{1'b0}}}
             - {{rhc_pkg::COMPONENT_BITS{1'b0}}, diff};
        snum_p = rhc_pkg::SNP_W'(snum);

        // The top of each dividend is already below its divisor, so only the
        // lowest DIV_STEPS bits need a step each.
        o_div.hue_rem = rhc_pkg::COMPONENT_BITS'(hnum >> rhc_pkg::DIV_STEPS);
        o_div.hue_acc = hnum[rhc_pkg::DIV_STEPS-1:0];
        o_div.sat_rem = rhc_pkg::COMPONENT_BITS'(snum_p >> rhc_pkg::DIV_STEPS);
        o_div.sat_acc = snum_p[rhc_pkg::DIV_STEPS-1:0];
        o_div.diff    = diff;
        o_div.mx      = i_mm.mx;
        o_div.undef   = (i_mm.mx == i_mm.mn);
    end

endmodule

// ----- src/rhc_div_step.sv -----
// One restoring division step for the hue and the saturation dividers.
// Uses rhc_pkg for the divider stage type.
module rhc_div_step (
    input  rhc_pkg::t_div i_div,
    output rhc_pkg::t_div o_div
);

    logic [rhc_pkg::COMPONENT_BITS:0] hue_trial;
    logic [rhc_pkg::COMPONENT_BITS:0] sat_trial;
    logic                             hue_ge;
    logic                             sat_ge;

    always_comb begin
        o_div = i_div;

        hue_trial = {i_div.hue_rem, i_div.hue_acc[rhc_pkg::DIV_STEPS-1]};
        hue_ge    = (hue_trial >= {1'b0, i_div.diff});
        o_div.hue_rem = hue_ge ? rhc_pkg::COMPONENT_BITS'(hue_trial - {1'b0, i_div.diff})
                               : rhc_pkg::COMPONENT_BITS'(hue_trial);
        o_div.hue_acc = {i_div.hue_acc[rhc_pkg::DIV_STEPS-2:0], hue_ge};

        sat_trial = {i_div.sat_rem, i_div.sat_acc[rhc_pkg::DIV_STEPS-1]};
        sat_ge    = (sat_trial >= {1'b0, i_div.mx});
        o_div.sat_rem = sat_ge ? rhc_pkg::COMPONENT_BITS'(sat_trial - {1'b0, i_div.mx})
                               : rhc_pkg::COMPONENT_BITS'(sat_trial);
        o_div.sat_acc = {i_div.sat_acc[rhc_pkg::DIV_STEPS-2:0], sat_ge};
    end

endmodule

// ----- src/rgb_to_hsv_convert_top.sv -----
// Top level of the pipelined RGB to HSV converter.
// Uses rhc_pkg, rhc_minmax, rhc_setup and rhc_div_step.
//
//   Channel   Handshake                   Payload
//   input     i_valid / o_stall           i_pixel (red, green, blue)
//   output    o_valid / i_stall           o_hsv (hue, saturation, brightness, hue_undefined)
//
// One pixel enters per clock while o_stall is low; the dividers take
// one step per stage.
// Reset clears every stage valid bit; the data registers are not reset.
// A stalled output holds its request while earlier stages keep closing up
// bubbles, so o_stall rises only once every stage holds a pixel.
module rgb_to_hsv_convert_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rhc_pkg::t_rgb_pixel i_pixel,
    output logic                o_valid,
    input  logic                i_stall,
    output rhc_pkg::t_hsv_pixel o_hsv
);

    localparam int LAST = rhc_pkg::NUM_STAGES - 1;

    logic [rhc_pkg::NUM_STAGES-1:0] r_vld;
    logic [rhc_pkg::NUM_STAGES-1:0] n_vld;
    logic [rhc_pkg::NUM_STAGES:0]   adv;

    rhc_pkg::t_rgb_pixel r_pix;
    rhc_pkg::t_minmax    r_mm;
    rhc_pkg::t_minmax    mm_comb;
    rhc_pkg::t_div       setup_comb;
    rhc_pkg::t_div       r_div  [rhc_pkg::DIV_STEPS+1];
    rhc_pkg::t_div       step_out [rhc_pkg::DIV_STEPS];
    rhc_pkg::t_hsv_pixel r_out;
    rhc_pkg::t_hsv_pixel n_out;
    logic [rhc_pkg::HUE_W-1:0] quot_h;

    // A stage may load when it is empty or when its contents move on.
    always_comb begin
        adv[rhc_pkg::NUM_STAGES] = !i_stall;
        for (int k = rhc_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld = r_vld;
        if (adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < rhc_pkg::NUM_STAGES; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    rhc_minmax u_minmax (
        .i_pixel (r_pix),
        .o_mm    (mm_comb)
    );

    rhc_setup u_setup (
        .i_mm  (r_mm),
        .o_div (setup_comb)
    );

    for (genvar j = 0; j < rhc_pkg::DIV_STEPS; j++) begin : g_div
        rhc_div_step u_step (
            .i_div (r_div[j]),
            .o_div (step_out[j])
        );

        always_ff @(posedge i_clk) begin
            if (adv[j+3]) begin
                r_div[j+1] <= step_out[j];
            end
        end
    end

    always_comb begin
        quot_h = rhc_pkg::HUE_W'(r_div[rhc_pkg::DIV_STEPS].hue_acc[rhc_pkg::HQ_W-1:0]);
        n_out.brightness    = r_div[rhc_pkg::DIV_STEPS].mx;
        n_out.hue_undefined = r_div[rhc_pkg::DIV_STEPS].undef;
        if (r_div[rhc_pkg::DIV_STEPS].undef) begin
            n_out.hue        = '0;
            n_out.saturation = '0;
        end else begin
            // Negative difference means a negative quotient, so it adds.
            n_out.hue = r_div[rhc_pkg::DIV_STEPS].neg
                      ? (r_div[rhc_pkg::DIV_STEPS].base + quot_h)
                      : (r_div[rhc_pkg::DIV_STEPS].base - quot_h);
            n_out.saturation =
                r_div[rhc_pkg::DIV_STEPS].sat_acc[rhc_pkg::COMPONENT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_pix <= i_pixel;
        end
        if (adv[1]) begin
            r_mm <= mm_comb;
        end
        if (adv[2]) begin
            r_div[0] <= setup_comb;
        end
        if (adv[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[LAST];
    assign o_hsv   = r_out;

endmodule
